>>> sv/dmcr_pkg.sv
// Shared types, constants and ramp helper for the dual motor command ramp.
package dmcr_pkg;

  localparam int PWM_WIDTH   = 16;
  localparam int CFG_WIDTH   = 15;
  localparam int PWM_MAX     = (2 ** (PWM_WIDTH - 1)) - 1;
  // |command| * scale stays below 2^30
  localparam int PROD_WIDTH  = 30;
  localparam int MULT_WIDTH  = PWM_WIDTH + CFG_WIDTH;
  // divide by 1000 as multiply by ceil(2^40 / 1000), exact over the product range
  localparam int RECIP_SHIFT = 40;
  localparam int RECIP_WIDTH = 31;
  localparam logic [RECIP_WIDTH-1:0] RECIP_1000 = 31'd1099511628;
  localparam int QUOT_WIDTH  = 21;

  localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 15'd1800;
  localparam logic [CFG_WIDTH-1:0] STEP_RESET  = 15'd70;
  localparam logic [CFG_WIDTH-1:0] SCALE_RESET = 15'd1000;

  typedef logic signed [PWM_WIDTH-1:0] pwm_t;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENABLE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_CLAMP_LEVEL = 3'd0,
    CFG_SLEW_STEP   = 3'd1,
    CFG_INVERT_A    = 3'd2,
    CFG_INVERT_B    = 3'd3,
    CFG_SCALE_A     = 3'd4,
    CFG_SCALE_B     = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic                 invert;
    logic [CFG_WIDTH-1:0] scale;
  } shape_cfg_t;

  // Move cur toward tgt by at most step, never past tgt.
  function automatic pwm_t approach(pwm_t cur, pwm_t tgt, logic [CFG_WIDTH-1:0] step);
    logic signed [PWM_WIDTH+1:0] c;
    logic signed [PWM_WIDTH+1:0] t;
    logic signed [PWM_WIDTH+1:0] s;
    logic signed [PWM_WIDTH+1:0] r;
    c = {{2{cur[PWM_WIDTH-1]}}, cur};
    t = {{2{tgt[PWM_WIDTH-1]}}, tgt};
    s = $signed({{(PWM_WIDTH + 2 - CFG_WIDTH){1'b0}}, step});
    r = c;
    if (c < t) begin
      r = (c + s > t) ? t : c + s;
    end else if (c > t) begin
      r = (c - s < t) ? t : c - s;
    end
    return r[PWM_WIDTH-1:0];
  endfunction

endpackage

>>> sv/dmcr_shape.sv
// Per-channel command shaping: invert, scale, and divide by 1000 over two stages.
module dmcr_shape (
  input  logic                                clk,
  input  logic                                advance,
  input  dmcr_pkg::pwm_t                      command,
  input  dmcr_pkg::shape_cfg_t                cfg,
  output logic                                neg,
  output logic [dmcr_pkg::QUOT_WIDTH-1:0]     quot
);

  logic signed [dmcr_pkg::PWM_WIDTH:0]       v;
  logic signed [dmcr_pkg::PWM_WIDTH:0]       mag_full;
  logic [dmcr_pkg::MULT_WIDTH-1:0]           prod_full;
  logic [dmcr_pkg::PROD_WIDTH+dmcr_pkg::RECIP_WIDTH-1:0] recip_full;
  logic [dmcr_pkg::PROD_WIDTH-1:0]           prod;
  logic                                      prod_neg;

  // Work on magnitude so the quotient truncates toward zero.
  always_comb begin
    v = {command[dmcr_pkg::PWM_WIDTH-1], command};
    if (cfg.invert) begin
      v = -v;
    end
    mag_full  = (v < 0) ? -v : v;
    prod_full = mag_full[dmcr_pkg::PWM_WIDTH-1:0] * cfg.scale;
  end

  assign recip_full = prod * dmcr_pkg::RECIP_1000;

  always_ff @(posedge clk) begin
    if (advance) begin
      prod     <= prod_full[dmcr_pkg::PROD_WIDTH-1:0];
      prod_neg <= (v < 0);
      quot     <= recip_full[dmcr_pkg::RECIP_SHIFT +: dmcr_pkg::QUOT_WIDTH];
      neg      <= prod_neg;
    end
  end

endmodule

>>> sv/dual_motor_command_ramp.sv
// Top level of the dual motor command ramp: pipeline control, state, ramp and output.
// A tick's result reaches m_axis through the input, product, quotient and output registers.
// Throughput: one input transaction per cycle; input stalls only while a tick sits in the
// last stage and the output register still holds an untaken result.
// Stages: input register, scale product, reciprocal quotient, then clamp/ramp into state.
// Reset (rst, synchronous): configuration registers return to defaults, enable and all state clear to zero.
module dual_motor_command_ramp (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // command_a[15:0], command_b[31:16], enable_in[32]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // enabled_out[0], target_a_out[16:1],
                                      // target_b_out[32:17], applied_a_out[48:33],
                                      // applied_b_out[64:49]
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  localparam int PW = dmcr_pkg::PWM_WIDTH;
  localparam int CW = dmcr_pkg::CFG_WIDTH;
  localparam int QW = dmcr_pkg::QUOT_WIDTH;

  // Configuration registers
  logic [CW-1:0] clamp_level;
  logic [CW-1:0] slew_step;
  logic          invert_a;
  logic          invert_b;
  logic [CW-1:0] scale_a_milli;
  logic [CW-1:0] scale_b_milli;

  // Block state
  logic           enabled_flag;
  dmcr_pkg::pwm_t target_a;
  dmcr_pkg::pwm_t target_b;
  dmcr_pkg::pwm_t applied_a;
  dmcr_pkg::pwm_t applied_b;

  // Pipeline control and payload
  logic            v1, v2, v3;
  dmcr_pkg::mode_t mode1, mode2, mode3;
  logic            en1, en2, en3;
  dmcr_pkg::pwm_t  cmd_a1, cmd_b1;

  logic            stall;
  logic            advance;
  logic            tick3;

  dmcr_pkg::shape_cfg_t shape_cfg_a, shape_cfg_b;
  logic                 neg_a, neg_b;
  logic [QW-1:0]        quot_a, quot_b;

  logic [CW-1:0]  bound;
  logic [CW-1:0]  mag_a, mag_b;
  dmcr_pkg::pwm_t target_a_next, target_b_next;
  dmcr_pkg::pwm_t applied_a_next, applied_b_next;

  // A tick in the last stage needs the output register; hold everything until it frees up.
  assign tick3         = v3 && (mode3 == dmcr_pkg::MODE_TICK);
  assign stall         = tick3 && m_axis_tvalid && !m_axis_tready;
  assign advance       = !stall;
  assign s_axis_tready = advance;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_level   <= dmcr_pkg::LIMIT_RESET;
      slew_step     <= dmcr_pkg::STEP_RESET;
      invert_a      <= 1'b0;
      invert_b      <= 1'b0;
      scale_a_milli <= dmcr_pkg::SCALE_RESET;
      scale_b_milli <= dmcr_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmcr_pkg::CFG_CLAMP_LEVEL: clamp_level   <= cfg_wdata;
        dmcr_pkg::CFG_SLEW_STEP:   slew_step     <= cfg_wdata;
        dmcr_pkg::CFG_INVERT_A:    invert_a      <= cfg_wdata[0];
        dmcr_pkg::CFG_INVERT_B:    invert_b      <= cfg_wdata[0];
        dmcr_pkg::CFG_SCALE_A:     scale_a_milli <= cfg_wdata;
        dmcr_pkg::CFG_SCALE_B:     scale_b_milli <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: valid and mode travel beside the shaping datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode1  <= dmcr_pkg::mode_t'(s_axis_tuser);
      cmd_a1 <= s_axis_tdata[15:0];
      cmd_b1 <= s_axis_tdata[31:16];
      en1    <= s_axis_tdata[32];
      mode2  <= mode1;
      en2    <= en1;
      mode3  <= mode2;
      en3    <= en2;
    end
  end

  assign shape_cfg_a = '{invert: invert_a, scale: scale_a_milli};
  assign shape_cfg_b = '{invert: invert_b, scale: scale_b_milli};

  dmcr_shape u_shape_a (
    .clk     (clk),
    .advance (advance),
    .command (cmd_a1),
    .cfg     (shape_cfg_a),
    .neg     (neg_a),
    .quot    (quot_a)
  );

  dmcr_shape u_shape_b (
    .clk     (clk),
    .advance (advance),
    .command (cmd_b1),
    .cfg     (shape_cfg_b),
    .neg     (neg_b),
    .quot    (quot_b)
  );

  // Saturate the quotient magnitude to the bound, then restore the sign.
  always_comb begin
    bound = (int'(clamp_level) > dmcr_pkg::PWM_MAX) ? CW'(dmcr_pkg::PWM_MAX) : clamp_level;
    mag_a = (quot_a > QW'(bound)) ? bound : quot_a[CW-1:0];
    mag_b = (quot_b > QW'(bound)) ? bound : quot_b[CW-1:0];
    target_a_next = neg_a ? -$signed({{(PW - CW){1'b0}}, mag_a})
                          :  $signed({{(PW - CW){1'b0}}, mag_a});
    target_b_next = neg_b ? -$signed({{(PW - CW){1'b0}}, mag_b})
                          :  $signed({{(PW - CW){1'b0}}, mag_b});
  end

  // Ramp on a tick; zero while disabled.
  always_comb begin
    if (enabled_flag) begin
      applied_a_next = dmcr_pkg::approach(applied_a, target_a, slew_step);
      applied_b_next = dmcr_pkg::approach(applied_b, target_b, slew_step);
    end else begin
      applied_a_next = '0;
      applied_b_next = '0;
    end
  end

  // Last stage: commit state in stream order, load the output register on ticks.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_flag <= 1'b0;
      target_a     <= '0;
      target_b     <= '0;
      applied_a    <= '0;
      applied_b    <= '0;
    end else if (advance && v3) begin
      case (mode3)
        dmcr_pkg::MODE_LOAD: begin
          target_a <= target_a_next;
          target_b <= target_b_next;
        end
        dmcr_pkg::MODE_ENABLE: begin
          enabled_flag <= en3;
          if (!en3) begin
            applied_a <= '0;
            applied_b <= '0;
          end
        end
        dmcr_pkg::MODE_TICK: begin
          applied_a <= applied_a_next;
          applied_b <= applied_b_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && tick3) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick3) begin
      m_axis_tdata <= {7'b0, applied_b_next, applied_a_next, target_b, target_a,
                       enabled_flag};
    end
  end

  // Disabled means both applied values sit at zero.
  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    !enabled_flag |-> (applied_a == '0) && (applied_b == '0))
    else $error("applied value nonzero while disabled");

  // A result only appears after a tick left the last stage.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(tick3))
    else $error("result produced without a tick");

  // A stall must freeze the last stage.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(quot_a) && $stable(quot_b) && $stable(mode3) && v3)
    else $error("last stage moved during a stall");

endmodule

>>> tb/dual_motor_command_ramp_tb.sv
// Self-checking testbench for the dual motor command ramp: directed, stall and random phases.
`timescale 1ns / 100ps

module dual_motor_command_ramp_tb;

  localparam int CW = dmcr_pkg::CFG_WIDTH;

  // Channel state as seen at the output of one update tick
  typedef struct {
    logic           enabled;
    dmcr_pkg::pwm_t target_a;
    dmcr_pkg::pwm_t target_b;
    dmcr_pkg::pwm_t applied_a;
    dmcr_pkg::pwm_t applied_b;
  } ramp_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // command_a[15:0], command_b[31:16], enable_in[32]
  logic [1:0]  s_axis_tuser;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // enabled_out[0], target_a_out[16:1], target_b_out[32:17],
                               // applied_a_out[48:33], applied_b_out[64:49]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_wdata;

  dual_motor_command_ramp i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Predicted register file
  logic [CW-1:0] cfg_limit;
  logic [CW-1:0] cfg_step;
  logic          cfg_inv_a;
  logic          cfg_inv_b;
  logic [CW-1:0] cfg_scale_a;
  logic [CW-1:0] cfg_scale_b;

  // Predicted channel state
  logic           enable_flag;
  dmcr_pkg::pwm_t tgt_a;
  dmcr_pkg::pwm_t tgt_b;
  dmcr_pkg::pwm_t app_a;
  dmcr_pkg::pwm_t app_b;

  ramp_result_t tick_expect_q[$];

  int fail_count = 0;
  bit rst_done = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold_cycles = 0;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses results
  initial begin : watchdog
    #(4_000_000);
    $display("dual_motor_command_ramp verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Invert, scale by thousandths (truncating toward zero), then saturate to +/- limit.
  // Done in 64 bits so negating -32768 and large products never wrap.
  function automatic dmcr_pkg::pwm_t shape_command(dmcr_pkg::pwm_t cmd, logic inv,
                                                   logic [CW-1:0] scale);
    longint v;
    longint bound;
    int     sc;
    sc    = scale;
    bound = cfg_limit;   // limit is at most 32767, so it is always the tighter bound
    v     = cmd;
    if (inv) v = -v;
    v = (v * sc) / 1000;
    if (v > bound) v = bound;
    if (v < -bound) v = -bound;
    return dmcr_pkg::pwm_t'(v);
  endfunction

  // Step toward the target by at most step, never overshooting it.
  function automatic dmcr_pkg::pwm_t step_toward(dmcr_pkg::pwm_t cur, dmcr_pkg::pwm_t tgt,
                                                 logic [CW-1:0] step);
    int c;
    int t;
    int s;
    c = cur;
    t = tgt;
    s = step;
    if (c < t) begin
      c = (c + s > t) ? t : c + s;
    end else if (c > t) begin
      c = (c - s < t) ? t : c - s;
    end
    return dmcr_pkg::pwm_t'(c);
  endfunction

  // Advance the predicted state for one accepted transaction; queue a result for ticks.
  task automatic ramp_predict(dmcr_pkg::mode_t mode, dmcr_pkg::pwm_t cmd_a,
                              dmcr_pkg::pwm_t cmd_b, logic en);
    ramp_result_t r;
    case (mode)
      dmcr_pkg::MODE_LOAD: begin
        tgt_a = shape_command(cmd_a, cfg_inv_a, cfg_scale_a);
        tgt_b = shape_command(cmd_b, cfg_inv_b, cfg_scale_b);
      end
      dmcr_pkg::MODE_ENABLE: begin
        enable_flag = en;
        // dropping enable clears the outputs immediately
        if (!en) begin
          app_a = '0;
          app_b = '0;
        end
      end
      dmcr_pkg::MODE_TICK: begin
        if (!enable_flag) begin
          app_a = '0;
          app_b = '0;
        end else begin
          app_a = step_toward(app_a, tgt_a, cfg_step);
          app_b = step_toward(app_b, tgt_b, cfg_step);
        end
        r.enabled   = enable_flag;
        r.target_a  = tgt_a;
        r.target_b  = tgt_b;
        r.applied_a = app_a;
        r.applied_b = app_b;
        tick_expect_q.push_back(r);
      end
      default: ;   // reserved mode: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Compare every output transaction against the oldest pending tick.
  always @(posedge clk) begin
    ramp_result_t want;
    if (rst_done && m_axis_tvalid && m_axis_tready) begin
      if (tick_expect_q.size() == 0) begin
        report_mismatch("unexpected output transaction", 1, 0);
      end else begin
        want = tick_expect_q.pop_front();
        if (m_axis_tdata[0] !== want.enabled)
          report_mismatch("enabled_out", m_axis_tdata[0], want.enabled);
        if ($signed(m_axis_tdata[16:1]) !== want.target_a)
          report_mismatch("target_a_out", $signed(m_axis_tdata[16:1]), want.target_a);
        if ($signed(m_axis_tdata[32:17]) !== want.target_b)
          report_mismatch("target_b_out", $signed(m_axis_tdata[32:17]), want.target_b);
        if ($signed(m_axis_tdata[48:33]) !== want.applied_a)
          report_mismatch("applied_a_out", $signed(m_axis_tdata[48:33]), want.applied_a);
        if ($signed(m_axis_tdata[64:49]) !== want.applied_b)
          report_mismatch("applied_b_out", $signed(m_axis_tdata[64:49]), want.applied_b);
        if (m_axis_tdata[71:65] !== 7'd0)
          report_mismatch("tdata padding", m_axis_tdata[71:65], 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random idle per result, plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    m_axis_tready = 1'b0;
    wait (rst_done);
    forever begin
      @(negedge clk);
      // take a pending long hold request first, else draw a normal gap
      if (rx_hold_cycles > 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = rx_idle_on ? $urandom_range(10, 0) : 0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      // hold ready until one transaction goes through
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction after a random gap; return right after the accepting edge
  // with valid still high so that valid need not drop between back-to-back items.
  task automatic send_command(dmcr_pkg::mode_t mode, dmcr_pkg::pwm_t cmd_a,
                              dmcr_pkg::pwm_t cmd_b, logic en);
    int gap;
    gap = tx_idle_on ? $urandom_range(10, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'd0, en, cmd_b, cmd_a};
    do @(posedge clk); while (!s_axis_tready);
    ramp_predict(mode, cmd_a, cmd_b, en);
  endtask

  // Drop valid and wait for every pending tick result to be taken.
  task automatic settle_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tick_expect_q.size() != 0) @(posedge clk);
  endtask

  // Settle, then let loads and enables still in the pipeline retire.
  task automatic wait_idle();
    settle_results();
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(dmcr_pkg::cfg_index_t idx, logic [CW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      dmcr_pkg::CFG_CLAMP_LEVEL: cfg_limit   = value;
      dmcr_pkg::CFG_SLEW_STEP:   cfg_step    = value;
      dmcr_pkg::CFG_INVERT_A:    cfg_inv_a   = value[0];
      dmcr_pkg::CFG_INVERT_B:    cfg_inv_b   = value[0];
      dmcr_pkg::CFG_SCALE_A:     cfg_scale_a = value;
      dmcr_pkg::CFG_SCALE_B:     cfg_scale_b = value;
      default: ;
    endcase
  endtask

  // Reprogram the whole register file once the block is idle.
  task automatic apply_regs(logic [CW-1:0] limit, logic [CW-1:0] step,
                            logic inv_a, logic inv_b,
                            logic [CW-1:0] sc_a, logic [CW-1:0] sc_b);
    wait_idle();
    write_reg(dmcr_pkg::CFG_CLAMP_LEVEL, limit);
    write_reg(dmcr_pkg::CFG_SLEW_STEP, step);
    write_reg(dmcr_pkg::CFG_INVERT_A, {14'd0, inv_a});
    write_reg(dmcr_pkg::CFG_INVERT_B, {14'd0, inv_b});
    write_reg(dmcr_pkg::CFG_SCALE_A, sc_a);
    write_reg(dmcr_pkg::CFG_SCALE_B, sc_b);
  endtask

  // Commands: rails, small values near zero, or any 16-bit pattern
  function automatic dmcr_pkg::pwm_t rand_command();
    int sel;
    int v;
    sel = $urandom_range(9, 0);
    case (sel)
      0: return dmcr_pkg::pwm_t'(-32768);
      1: return dmcr_pkg::pwm_t'(32767);
      2, 3, 4: begin
        v = int'($urandom_range(6000, 0)) - 3000;
        return dmcr_pkg::pwm_t'(v);
      end
      default: return dmcr_pkg::pwm_t'($urandom_range(16'hffff, 0));
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_reg15();
    int sel;
    sel = $urandom_range(7, 0);
    case (sel)
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'h7fff;
      3: return CW'($urandom_range(32767, 1));
      default: return CW'($urandom_range(3000, 1));
    endcase
  endfunction

  // One random transaction; mostly loads and ticks with enable held high so the ramp
  // actually runs, some disables and reserved-mode noise. counted is low for noise.
  task automatic send_random_item(output bit counted);
    int              r;
    dmcr_pkg::mode_t mode;
    logic            en;
    r = $urandom_range(99, 0);
    if (r < 5)       mode = dmcr_pkg::MODE_NONE;
    else if (r < 33) mode = dmcr_pkg::MODE_LOAD;
    else if (r < 45) mode = dmcr_pkg::MODE_ENABLE;
    else             mode = dmcr_pkg::MODE_TICK;
    en = ($urandom_range(4, 0) != 0);
    send_command(mode, rand_command(), rand_command(), en);
    counted = (mode != dmcr_pkg::MODE_NONE);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Defaults after reset, enable and disable behavior, rail commands, zero gain on A,
  // zero limit and zero step, truncation of small products, reserved mode.
  task automatic test_directed_cases();
    // reset values: limit 1800, step 70, unity gain
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    send_command(dmcr_pkg::MODE_LOAD, 16'sd32767, -16'sd32768, 1'b0);   // load while disabled
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    send_command(dmcr_pkg::MODE_ENABLE, 16'sd0, 16'sd0, 1'b1);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    send_command(dmcr_pkg::MODE_ENABLE, 16'sd0, 16'sd0, 1'b1);   // re-enable keeps outputs
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    send_command(dmcr_pkg::MODE_ENABLE, 16'sd0, 16'sd0, 1'b0);   // disable clears at once
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b1);
    send_command(dmcr_pkg::MODE_NONE, rand_command(), rand_command(), 1'b1);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);

    // widest settings: negating the most negative command must saturate, not wrap
    apply_regs(15'h7fff, 15'h7fff, 1'b1, 1'b0, 15'h7fff, 15'h7fff);
    send_command(dmcr_pkg::MODE_ENABLE, 16'sd0, 16'sd0, 1'b1);
    send_command(dmcr_pkg::MODE_LOAD, -16'sd32768, -16'sd32768, 1'b0);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    send_command(dmcr_pkg::MODE_LOAD, 16'sd1, -16'sd1, 1'b0);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);

    // zero limit, zero step, zero gain on A
    apply_regs(15'd0, 15'd0, 1'b0, 1'b1, 15'd0, 15'd1000);
    send_command(dmcr_pkg::MODE_LOAD, 16'sd12345, 16'sd12345, 1'b0);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);

    // gain of one thousandth: products under 1000 truncate toward zero
    apply_regs(15'd1800, 15'd1, 1'b0, 1'b0, 15'd1, 15'd1);
    send_command(dmcr_pkg::MODE_LOAD, 16'sd999, -16'sd1999, 1'b0);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
  endtask

  // Hold the output off for a long stretch while ticks keep coming so the pipeline
  // fills and stalls its input, then pause the sender until every result is back.
  task automatic test_backpressure();
    apply_regs(15'd1800, 15'd70, 1'b0, 1'b0, 15'd1000, 15'd1000);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_command(dmcr_pkg::MODE_ENABLE, 16'sd0, 16'sd0, 1'b1);
    send_command(dmcr_pkg::MODE_LOAD, 16'sd1500, -16'sd900, 1'b0);
    rx_hold_cycles = 300;
    repeat (40) send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    settle_results();
    repeat (20) begin
      send_command(dmcr_pkg::MODE_TICK, 16'sd0, 16'sd0, 1'b0);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Random traffic over several register settings, extremes first; every third
  // phase runs with no idling on either side.
  task automatic test_random_phases();
    int  counted_items;
    bit  counted;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: apply_regs(15'h7fff, 15'h7fff, 1'b1, 1'b1, 15'h7fff, 15'h7fff);
        1: apply_regs(15'd1, 15'd1, 1'b0, 1'b0, 15'd1, 15'd0);
        2: apply_regs(15'd1800, 15'd70, 1'b0, 1'b0, 15'd1000, 15'd1000);
        default: apply_regs(rand_reg15(), rand_reg15(), 1'($urandom_range(1, 0)),
                            1'($urandom_range(1, 0)), rand_reg15(), rand_reg15());
      endcase
      tx_idle_on = (p % 3 != 2);
      rx_idle_on = (p % 3 != 2);
      counted_items = 0;
      while (counted_items < 160) begin
        send_random_item(counted);
        if (counted) counted_items++;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = dmcr_pkg::MODE_LOAD;
    cfg_we        = 1'b0;
    cfg_index     = dmcr_pkg::CFG_CLAMP_LEVEL;
    cfg_wdata     = '0;

    // predictor starts from the reset state
    cfg_limit   = dmcr_pkg::LIMIT_RESET;
    cfg_step    = dmcr_pkg::STEP_RESET;
    cfg_inv_a   = 1'b0;
    cfg_inv_b   = 1'b0;
    cfg_scale_a = dmcr_pkg::SCALE_RESET;
    cfg_scale_b = dmcr_pkg::SCALE_RESET;
    enable_flag = 1'b0;
    tgt_a       = '0;
    tgt_b       = '0;
    app_a       = '0;
    app_b       = '0;

    // hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rst_done = 1'b1;

    test_directed_cases();
    test_backpressure();
    test_random_phases();

    // drain, then give the pipeline time to show any stray result
    settle_results();
    repeat (10) @(posedge clk);
    if (tick_expect_q.size() != 0)
      report_mismatch("results still pending", tick_expect_q.size(), 0);

    if (fail_count == 0) begin
      $display("dual_motor_command_ramp verification clean");
    end else begin
      $display("dual_motor_command_ramp verification failed");
    end
    $finish;
  end

endmodule
